/* src/line_follow_pid_steering_assert.svh */
// Assertion macros shared by the line-following steering controller.
`ifndef LINE_FOLLOW_PID_STEERING_ASSERT_SVH
`define LINE_FOLLOW_PID_STEERING_ASSERT_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define LFPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define LFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lfps_pkg.sv */
// Types, constants and helpers of the line-following steering controller.
package lfps_pkg;

  localparam int CNT_W      = 24;
  localparam int COL_W      = 12;
  localparam int FW_W       = 13;
  localparam int HALF_W     = FW_W - 1;
  localparam int GRAY_W     = 8;
  localparam int SPD_W      = 5;
  localparam int ERR_W      = 2;
  localparam int PID_W      = 24;
  localparam int INTEG_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int TOP_SPEED   = 20;
  localparam int SPEED_CAP   = 20;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam logic [SPD_W-1:0] SPEED_MAX = SPD_W'(SPEED_CAP);
  localparam logic [SPD_W-1:0] FINAL_SPEED =
    SPD_W'((TOP_SPEED > SPEED_CAP) ? SPEED_CAP : TOP_SPEED);

  localparam logic signed [ERR_W-1:0] ERR_ZERO = 2'sb00;
  localparam logic signed [ERR_W-1:0] ERR_POS  = 2'sb01;
  localparam logic signed [ERR_W-1:0] ERR_NEG  = 2'sb11;

  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINISH_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd6;

  typedef struct packed {
    logic [6:0]        cruise_speed;
    logic [8:0]        finish_level;
    logic [GRAY_W-1:0] gray_threshold;
    logic [15:0]       gain_p;
    logic [15:0]       gain_i;
    logic [15:0]       gain_d;
    logic [FW_W-1:0]   frame_width;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] half_pixels;
    logic [CNT_W-1:0] dark_left;
    logic [CNT_W-1:0] dark_right;
  } frame_sum_t;

  typedef struct packed {
    logic       push;
    frame_sum_t data;
  } fifo_wr_t;

  typedef struct packed {
    logic       empty;
    frame_sum_t data;
  } fifo_rd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

/* src/lfps_intf.sv */
// Pixel request and steering command channel interfaces.
interface lfps_pix_if;
  logic                       valid;
  logic                       ready;
  logic [lfps_pkg::GRAY_W-1:0] gray;
  logic                       line_last;
  logic                       frame_last;

  modport source (output valid, gray, line_last, frame_last, input ready);
  modport sink (input valid, gray, line_last, frame_last, output ready);
endinterface

interface lfps_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [lfps_pkg::SPD_W-1:0]        left_speed;
  logic [lfps_pkg::SPD_W-1:0]        right_speed;
  logic signed [lfps_pkg::ERR_W-1:0] steer_error;
  logic signed [lfps_pkg::PID_W-1:0] pid_out;
  logic                              rush;

  modport source (output valid, left_speed, right_speed, steer_error, pid_out, rush,
                  input ready);
  modport sink (input valid, left_speed, right_speed, steer_error, pid_out, rush,
                output ready);
endinterface

/* src/lfps_front.sv */
// Pixel front end: counts dark pixels per half frame and queues frame summaries.
module lfps_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfps_pkg::cfg_t    cfg_i,
  lfps_pix_if.sink          pix_i,
  input  logic              full_i,
  output lfps_pkg::fifo_wr_t wr_o
);
  import lfps_pkg::*;

  logic [COL_W-1:0]  column_q, column_d;
  logic [CNT_W-1:0]  hp_q, hp_d, dl_q, dl_d, dr_q, dr_d;
  logic [CNT_W-1:0]  hp_upd, dl_upd, dr_upd;
  logic [HALF_W-1:0] half;
  logic              in_left, in_right, dark, accept;

  assign half     = cfg_i.frame_width[FW_W-1:1];
  assign in_left  = column_q < half;
  assign in_right = !in_left && ({1'b0, column_q} < {half, 1'b0});
  assign dark     = pix_i.gray <= cfg_i.gray_threshold;
  assign accept   = pix_i.valid && pix_i.ready;

  assign pix_i.ready = !full_i;

  assign hp_upd = in_left ? sat_inc(hp_q) : hp_q;
  assign dl_upd = (in_left && dark) ? sat_inc(dl_q) : dl_q;
  assign dr_upd = (in_right && dark) ? sat_inc(dr_q) : dr_q;

  assign wr_o.push             = accept && pix_i.frame_last;
  assign wr_o.data.half_pixels = hp_upd;
  assign wr_o.data.dark_left   = dl_upd;
  assign wr_o.data.dark_right  = dr_upd;

  always_comb begin
    column_d = column_q;
    hp_d     = hp_q;
    dl_d     = dl_q;
    dr_d     = dr_q;
    if (accept) begin
      if (pix_i.frame_last) begin
        column_d = '0;
        hp_d     = '0;
        dl_d     = '0;
        dr_d     = '0;
      end else begin
        hp_d = hp_upd;
        dl_d = dl_upd;
        dr_d = dr_upd;
        if (pix_i.line_last) begin
          column_d = '0;
        end else if (column_q != COL_MAX) begin
          column_d = column_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      hp_q     <= '0;
      dl_q     <= '0;
      dr_q     <= '0;
    end else begin
      column_q <= column_d;
      hp_q     <= hp_d;
      dl_q     <= dl_d;
      dr_q     <= dr_d;
    end
  end

endmodule

/* src/lfps_fifo.sv */
// Short register queue of frame summaries between the front and back ends.
module lfps_fifo #(
  parameter int Depth = lfps_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfps_pkg::fifo_wr_t wr_i,
  input  logic               pop_i,
  output lfps_pkg::fifo_rd_t rd_o,
  output logic               full_o
);
  import lfps_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  frame_sum_t      mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = cnt_q == CntW'(Depth);
  assign rd_o.empty = cnt_q == '0;
  assign rd_o.data  = mem_q[rptr_q];
  assign do_push    = wr_i.push && !full_o;
  assign do_pop     = pop_i && !rd_o.empty;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wr_i.data;
    end
  end

endmodule

/* src/lfps_back.sv */
// Back end: rush test, steering error, PID step and motor speed pipeline.
module lfps_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfps_pkg::cfg_t     cfg_i,
  input  lfps_pkg::fifo_rd_t rd_i,
  output logic               pop_o,
  lfps_cmd_if.source         cmd_o
);
  import lfps_pkg::*;

  localparam int SumW = 35;
  localparam int VW   = 26;

  function automatic logic [SPD_W-1:0] speed_of(input logic signed [VW-1:0] v);
    logic [VW-9:0] s;
    s = v[VW-1:8];
    if (v <= 0) begin
      speed_of = '0;
    end else if (s > (VW-8)'(SPEED_CAP)) begin
      speed_of = SPEED_MAX;
    end else begin
      speed_of = s[SPD_W-1:0];
    end
  endfunction

  logic en, finished_q, finished_d;

  // Stage A: rush test and error from the queue head.
  logic [CNT_W-1:0]        h, dl, dr, diff_lr, diff_rl;
  logic [32:0]             thr_prod, dl_sh, dr_sh;
  logic [28:0]             x20_lr, x20_rl, h_ext;
  logic                    rush_now;
  logic signed [ERR_W-1:0] err_now;
  logic                    a_valid_q, a_rush_q;
  logic signed [ERR_W-1:0] a_err_q;

  // Stage B: state update and partial products.
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [ERR_W-1:0]   last_err_q;
  logic signed [ERR_W:0]     d_err;
  logic signed [17:0]        pterm;
  logic signed [32:0]        iterm;
  logic signed [19:0]        dterm;
  logic                      b_valid_q, b_rush_q;
  logic signed [ERR_W-1:0]   b_err_q;
  logic signed [17:0]        b_pterm_q;
  logic signed [32:0]        b_iterm_q;
  logic signed [19:0]        b_dterm_q;

  // Stage C: sum and saturation.
  logic signed [SumW-1:0]  pid_sum;
  logic signed [PID_W-1:0] pid_sat;
  logic                    c_valid_q, c_rush_q;
  logic signed [ERR_W-1:0] c_err_q;
  logic signed [PID_W-1:0] c_pid_q;

  // Output register.
  logic signed [VW-1:0]    base, v_left, v_right;
  logic                    out_valid_q, out_rush_q;
  logic [SPD_W-1:0]        out_left_q, out_right_q;
  logic signed [ERR_W-1:0] out_err_q;
  logic signed [PID_W-1:0] out_pid_q;

  assign en    = !out_valid_q || cmd_o.ready;
  assign pop_o = en && !rd_i.empty;

  assign h        = rd_i.data.half_pixels;
  assign dl       = rd_i.data.dark_left;
  assign dr       = rd_i.data.dark_right;
  assign thr_prod = 33'(cfg_i.finish_level) * 33'(h);
  assign dl_sh    = {1'b0, dl, 8'b0};
  assign dr_sh    = {1'b0, dr, 8'b0};
  assign rush_now = (dl_sh <= thr_prod) && (dr_sh <= thr_prod);
  assign diff_lr  = dl - dr;
  assign diff_rl  = dr - dl;
  assign x20_lr   = {1'b0, diff_lr, 4'b0} + {3'b0, diff_lr, 2'b0};
  assign x20_rl   = {1'b0, diff_rl, 4'b0} + {3'b0, diff_rl, 2'b0};
  assign h_ext    = {5'b0, h};

  always_comb begin
    if (dl > dr && x20_lr > h_ext) begin
      err_now = ERR_POS;
    end else if (dr > dl && x20_rl > h_ext) begin
      err_now = ERR_NEG;
    end else begin
      err_now = ERR_ZERO;
    end
  end

  assign finished_d = finished_q || (pop_o && rush_now);

  always_comb begin
    integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(a_err_q);
    if (integ_sum > (INTEG_W+1)'(32767)) begin
      integ_d = 16'sh7FFF;
    end else if (integ_sum < -(INTEG_W+1)'(32768)) begin
      integ_d = 16'sh8000;
    end else begin
      integ_d = integ_sum[INTEG_W-1:0];
    end
  end

  assign d_err = (ERR_W+1)'(a_err_q) - (ERR_W+1)'(last_err_q);

  always_comb begin
    case (a_err_q)
      ERR_POS: pterm = $signed({2'b0, cfg_i.gain_p});
      ERR_NEG: pterm = -$signed({2'b0, cfg_i.gain_p});
      default: pterm = '0;
    endcase
  end

  assign iterm = $signed({1'b0, cfg_i.gain_i}) * integ_d;
  assign dterm = 20'($signed({1'b0, cfg_i.gain_d}) * d_err);

  assign pid_sum = SumW'(b_pterm_q) + SumW'(b_iterm_q) + SumW'(b_dterm_q);

  always_comb begin
    if (pid_sum > SumW'(8388607)) begin
      pid_sat = 24'sh7FFFFF;
    end else if (pid_sum < -SumW'(8388608)) begin
      pid_sat = 24'sh800000;
    end else begin
      pid_sat = pid_sum[PID_W-1:0];
    end
  end

  assign base    = $signed({11'b0, cfg_i.cruise_speed, 8'b0});
  assign v_left  = base - VW'(c_pid_q);
  assign v_right = base + VW'(c_pid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q  <= 1'b0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_err_q  <= ERR_ZERO;
    end else if (en) begin
      finished_q  <= finished_d;
      a_valid_q   <= pop_o && !finished_q;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
      if (a_valid_q && !a_rush_q) begin
        integ_q    <= integ_d;
        last_err_q <= a_err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_rush_q  <= rush_now;
      a_err_q   <= err_now;
      b_rush_q  <= a_rush_q;
      b_err_q   <= a_err_q;
      b_pterm_q <= pterm;
      b_iterm_q <= iterm;
      b_dterm_q <= dterm;
      c_rush_q  <= b_rush_q;
      c_err_q   <= b_err_q;
      c_pid_q   <= pid_sat;
      if (c_rush_q) begin
        out_left_q  <= FINAL_SPEED;
        out_right_q <= FINAL_SPEED;
        out_err_q   <= ERR_ZERO;
        out_pid_q   <= '0;
        out_rush_q  <= 1'b1;
      end else begin
        out_left_q  <= speed_of(v_left);
        out_right_q <= speed_of(v_right);
        out_err_q   <= c_err_q;
        out_pid_q   <= c_pid_q;
        out_rush_q  <= 1'b0;
      end
    end
  end

  assign cmd_o.valid       = out_valid_q;
  assign cmd_o.left_speed  = out_left_q;
  assign cmd_o.right_speed = out_right_q;
  assign cmd_o.steer_error = out_err_q;
  assign cmd_o.pid_out     = out_pid_q;
  assign cmd_o.rush        = out_rush_q;

endmodule

/* src/line_follow_pid_steering.sv */
// Line-following PID steering controller fed by a raster stream of gray pixels.
//
// pix_i takes one pixel request per cycle (gray, line_last, frame_last) while its
// ready is high. Dark pixels are counted per half frame in the pixel front end;
// the request carrying frame_last closes the frame and pushes a summary into a
// short queue. The back end pipeline turns each summary into one command on cmd_o
// through stages A, B and C and the output register, and can take one summary per
// cycle unless cmd_o stalls. A final rush command is sent once; no more follow.
// Pixels are always taken at one per cycle unless the summary queue is full,
// which happens only when cmd_o stalls while frames keep closing quickly.
// A stall on cmd_o holds the command register and freezes the back pipeline.
// Registers must be written through cfg_we_i, cfg_idx_i and cfg_data_i only while
// idle; the block does not enforce this. Reset clears the counters, the PID state,
// the queue and the pipeline, and loads the default register values.
`include "line_follow_pid_steering_assert.svh"

module line_follow_pid_steering #(
  parameter int QueueDepth = lfps_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  lfps_pix_if.sink                            pix_i,
  lfps_cmd_if.source                          cmd_o
);
  import lfps_pkg::*;

  cfg_t     cfg_q, cfg_d;
  fifo_wr_t fifo_wr;
  fifo_rd_t fifo_rd;
  logic     fifo_full, fifo_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CRUISE_SPEED:   cfg_d.cruise_speed   = cfg_data_i[6:0];
        REG_FINISH_LEVEL:   cfg_d.finish_level   = cfg_data_i[8:0];
        REG_GRAY_THRESHOLD: cfg_d.gray_threshold = cfg_data_i[GRAY_W-1:0];
        REG_GAIN_P:         cfg_d.gain_p         = cfg_data_i;
        REG_GAIN_I:         cfg_d.gain_i         = cfg_data_i;
        REG_GAIN_D:         cfg_d.gain_d         = cfg_data_i;
        REG_FRAME_WIDTH:    cfg_d.frame_width    = cfg_data_i[FW_W-1:0];
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed   <= 7'd20;
      cfg_q.finish_level   <= 9'd0;
      cfg_q.gray_threshold <= 8'd80;
      cfg_q.gain_p         <= 16'd2560;
      cfg_q.gain_i         <= 16'd128;
      cfg_q.gain_d         <= 16'd0;
      cfg_q.frame_width    <= 13'd640;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lfps_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pix_i  (pix_i),
    .full_i (fifo_full),
    .wr_o   (fifo_wr)
  );

  lfps_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (fifo_wr),
    .pop_i  (fifo_pop),
    .rd_o   (fifo_rd),
    .full_o (fifo_full)
  );

  lfps_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .rd_i   (fifo_rd),
    .pop_o  (fifo_pop),
    .cmd_o  (cmd_o)
  );

  `LFPS_ASSERT_NOW(a_speed_cap, cmd_o.valid,
    (cmd_o.left_speed <= SPEED_MAX) && (cmd_o.right_speed <= SPEED_MAX),
    "Motor speed above the cap.")

  `LFPS_ASSERT_NOW(a_rush_clean, cmd_o.valid && cmd_o.rush,
    (cmd_o.steer_error == ERR_ZERO) && (cmd_o.pid_out == '0),
    "Rush command carries a steering value.")

  `LFPS_ASSERT_NEXT(a_silent_after_rush, cmd_o.valid && cmd_o.ready && cmd_o.rush,
    !cmd_o.valid, "Command issued after the final rush.")

  `LFPS_ASSERT_NOW(a_no_push_when_full, fifo_full, !fifo_wr.push,
    "Frame summary pushed into a full queue.")

endmodule

/* sim/tb.sv */
// Testbench of the line-following steering controller: pixel frames against a PID predictor.
module tb;
  import lfps_pkg::*;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              line_last;
    logic              frame_last;
  } pixel_t;

  typedef struct packed {
    logic [SPD_W-1:0]        left_speed;
    logic [SPD_W-1:0]        right_speed;
    logic signed [ERR_W-1:0] steer_error;
    logic signed [PID_W-1:0] pid_out;
    logic                    rush;
  } steer_cmd_t;

  localparam longint PID_HI   = (longint'(1) << (PID_W - 1)) - 1;
  localparam longint PID_LO   = -(longint'(1) << (PID_W - 1));
  localparam int     INTEG_HI = (1 << (INTEG_W - 1)) - 1;
  localparam int     INTEG_LO = -(1 << (INTEG_W - 1));

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lfps_pix_if pix ();
  lfps_cmd_if cmd ();

  line_follow_pid_steering i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .cmd_o      (cmd)
  );

  always #1 clk_i = ~clk_i;

  cfg_t             reg_shadow;
  logic [COL_W-1:0] col_pos;
  logic [CNT_W-1:0] left_px;
  logic [CNT_W-1:0] dark_l;
  logic [CNT_W-1:0] dark_r;
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [ERR_W-1:0]   prev_err;
  bit               run_over;

  pixel_t     pending_pixels[$];
  pixel_t     frame_buf[$];
  steer_cmd_t steer_cmds_due[$];
  pixel_t     on_wire;
  steer_cmd_t cmd_want;
  int         queued_items = 0;
  int         mismatch_cnt = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         sink_hold_cycles = 0;

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [SPD_W-1:0] motor_speed(input longint v);
    if (v <= 0) return '0;
    if (v / 256 > SPEED_CAP) return SPD_W'(SPEED_CAP);
    return SPD_W'(v / 256);
  endfunction

  task automatic track_pixel(input pixel_t p);
    int half_w;
    int e;
    int integ_n;
    logic [CNT_W-1:0] h;
    logic [CNT_W-1:0] dl;
    logic [CNT_W-1:0] dr;
    longint pid;
    longint base;
    steer_cmd_t c;
    if (run_over) return;
    half_w = int'(reg_shadow.frame_width) / 2;
    if (int'(col_pos) < half_w) begin
      left_px = count_up(left_px);
      if (p.gray <= reg_shadow.gray_threshold) dark_l = count_up(dark_l);
    end else if (int'(col_pos) < 2 * half_w) begin
      if (p.gray <= reg_shadow.gray_threshold) dark_r = count_up(dark_r);
    end
    if (p.line_last) begin
      col_pos = '0;
    end else if (col_pos != COL_MAX) begin
      col_pos = col_pos + 1'b1;
    end
    if (!p.frame_last) return;
    h = left_px;
    dl = dark_l;
    dr = dark_r;
    col_pos = '0;
    left_px = '0;
    dark_l = '0;
    dark_r = '0;
    if (longint'(dl) * 256 <= longint'(reg_shadow.finish_level) * longint'(h) &&
        longint'(dr) * 256 <= longint'(reg_shadow.finish_level) * longint'(h)) begin
      run_over = 1'b1;
      c.left_speed = FINAL_SPEED;
      c.right_speed = FINAL_SPEED;
      c.steer_error = ERR_ZERO;
      c.pid_out = '0;
      c.rush = 1'b1;
      steer_cmds_due.push_back(c);
      return;
    end
    if (dl > dr && 20 * longint'(dl - dr) > longint'(h)) begin
      e = 1;
    end else if (dr > dl && 20 * longint'(dr - dl) > longint'(h)) begin
      e = -1;
    end else begin
      e = 0;
    end
    integ_n = int'(integ_acc) + e;
    if (integ_n > INTEG_HI) integ_n = INTEG_HI;
    if (integ_n < INTEG_LO) integ_n = INTEG_LO;
    integ_acc = INTEG_W'(integ_n);
    pid = longint'(reg_shadow.gain_p) * e + longint'(reg_shadow.gain_i) * longint'(integ_acc)
        + longint'(reg_shadow.gain_d) * (e - int'(prev_err));
    prev_err = ERR_W'(e);
    if (pid > PID_HI) pid = PID_HI;
    if (pid < PID_LO) pid = PID_LO;
    base = longint'(reg_shadow.cruise_speed) * 256;
    c.left_speed = motor_speed(base - pid);
    c.right_speed = motor_speed(base + pid);
    c.steer_error = ERR_W'(e);
    c.pid_out = PID_W'(pid);
    c.rush = 1'b0;
    steer_cmds_due.push_back(c);
  endtask

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.gray <= '0;
      pix.line_last <= 1'b0;
      pix.frame_last <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) track_pixel(on_wire);
      if (!pix.valid || pix.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          on_wire = pending_pixels.pop_front();
          pix.valid <= 1'b1;
          pix.gray <= on_wire.gray;
          pix.line_last <= on_wire.line_last;
          pix.frame_last <= on_wire.frame_last;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (sink_hold_cycles > 0) sink_hold_cycles <= sink_hold_cycles - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd.ready <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        if (steer_cmds_due.size() == 0) begin
          $display("%0t: command with none expected, actual left %0d right %0d rush %0d",
                   $time, cmd.left_speed, cmd.right_speed, cmd.rush);
          mismatch_cnt++;
        end else begin
          cmd_want = steer_cmds_due.pop_front();
          compare_field("left_speed", cmd_want.left_speed, cmd.left_speed);
          compare_field("right_speed", cmd_want.right_speed, cmd.right_speed);
          compare_field("steer_error", cmd_want.steer_error, cmd.steer_error);
          compare_field("pid_out", cmd_want.pid_out, cmd.pid_out);
          compare_field("rush", cmd_want.rush, cmd.rush);
        end
      end
      cmd.ready <= (sink_hold_cycles == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CRUISE_SPEED:   reg_shadow.cruise_speed = value[6:0];
      REG_FINISH_LEVEL:   reg_shadow.finish_level = value[8:0];
      REG_GRAY_THRESHOLD: reg_shadow.gray_threshold = value[GRAY_W-1:0];
      REG_GAIN_P:         reg_shadow.gain_p = value;
      REG_GAIN_I:         reg_shadow.gain_i = value;
      REG_GAIN_D:         reg_shadow.gain_d = value;
      REG_FRAME_WIDTH:    reg_shadow.frame_width = value[FW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input int ms, input int rt, input int thr, input int gp,
                           input int gi, input int gd, input int fw);
    set_reg(REG_CRUISE_SPEED, CFG_DATA_W'(ms));
    set_reg(REG_FINISH_LEVEL, CFG_DATA_W'(rt));
    set_reg(REG_GRAY_THRESHOLD, CFG_DATA_W'(thr));
    set_reg(REG_GAIN_P, CFG_DATA_W'(gp));
    set_reg(REG_GAIN_I, CFG_DATA_W'(gi));
    set_reg(REG_GAIN_D, CFG_DATA_W'(gd));
    set_reg(REG_FRAME_WIDTH, CFG_DATA_W'(fw));
  endtask

  task automatic settle();
    while (pending_pixels.size() != 0 || pix.valid || steer_cmds_due.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic int pick_gain();
    case ($urandom_range(3))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(4095);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic int pick_bias();
    case ($urandom_range(4))
      0: return 0;
      1: return 10;
      2: return 50;
      3: return 90;
      default: return 100;
    endcase
  endfunction

  function automatic logic [GRAY_W-1:0] pick_gray(input int dark_pct);
    int thr;
    thr = int'(reg_shadow.gray_threshold);
    if (dark_pct > 0 && dark_pct < 100 && $urandom_range(99) < 10)
      return GRAY_W'($urandom_range(255));
    if ($urandom_range(99) < dark_pct)
      return ($urandom_range(4) == 0) ? GRAY_W'(thr) : GRAY_W'($urandom_range(thr));
    if (thr == 255) return GRAY_W'(255);
    return ($urandom_range(4) == 0) ? GRAY_W'(thr + 1) : GRAY_W'($urandom_range(255, thr + 1));
  endfunction

  task automatic add_pixel(input logic [GRAY_W-1:0] gray, input logic ll, input logic fl);
    pixel_t p;
    p.gray = gray;
    p.line_last = ll;
    p.frame_last = fl;
    frame_buf.push_back(p);
  endtask

  // Unless the frame is meant to end the run, a frame that would trigger the
  // final rush gets its whole left half darkened so that it steers instead.
  task automatic commit_frame(input bit may_finish);
    int half_w;
    int col;
    int hpx;
    int dl;
    int dr;
    int rt;
    int left_at[$];
    half_w = int'(reg_shadow.frame_width) / 2;
    rt = int'(reg_shadow.finish_level);
    col = 0;
    hpx = 0;
    dl = 0;
    dr = 0;
    foreach (frame_buf[i]) begin
      if (col < half_w) begin
        hpx++;
        left_at.push_back(i);
        if (frame_buf[i].gray <= reg_shadow.gray_threshold) dl++;
      end else if (col < 2 * half_w && frame_buf[i].gray <= reg_shadow.gray_threshold) begin
        dr++;
      end
      col = frame_buf[i].line_last ? 0 : ((col < int'(COL_MAX)) ? col + 1 : col);
    end
    if (!may_finish && dl * 256 <= rt * hpx && dr * 256 <= rt * hpx) begin
      foreach (left_at[j]) frame_buf[left_at[j]].gray = '0;
    end
    foreach (frame_buf[i]) pending_pixels.push_back(frame_buf[i]);
    queued_items += frame_buf.size();
    frame_buf.delete();
  endtask

  task automatic build_frame(input int n_lines, input int fixed_len);
    int fw;
    int half_w;
    int pl;
    int pr;
    int len;
    bit messy;
    fw = int'(reg_shadow.frame_width);
    half_w = fw / 2;
    pl = pick_bias();
    pr = pick_bias();
    messy = $urandom_range(99) < 25;
    for (int l = 0; l < n_lines; l++) begin
      if (fixed_len != 0) begin
        len = fixed_len;
      end else if (messy && $urandom_range(1) == 1) begin
        len = $urandom_range(fw + 4, 1);
      end else begin
        len = fw;
      end
      for (int k = 0; k < len; k++) begin
        add_pixel(pick_gray((k < half_w) ? pl : pr), k == len - 1,
                  (l == n_lines - 1) && (k == len - 1));
      end
    end
    if (messy && $urandom_range(1) == 1) frame_buf[frame_buf.size() - 1].line_last = 1'b0;
    commit_frame(1'b0);
  endtask

  initial begin
    int mark;
    int thr;
    reg_shadow = '{cruise_speed: 7'd20, finish_level: 9'd0, gray_threshold: 8'd80,
                   gain_p: 16'd2560, gain_i: 16'd128, gain_d: 16'd0, frame_width: 13'd640};
    col_pos = '0;
    left_px = '0;
    dark_l = '0;
    dark_r = '0;
    integ_acc = '0;
    prev_err = '0;
    run_over = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    pix.gray = '0;
    pix.line_last = 1'b0;
    pix.frame_last = 1'b0;
    cmd.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    load_regs(20, 0, 80, 2560, 128, 0, 4);
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd80, 1'b1, 1'b1);
    commit_frame(1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd81, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b1, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b0, 1'b1);
    commit_frame(1'b0);
    // A frame of one pixel: the closing pixel is counted before the decision.
    add_pixel(8'd80, 1'b1, 1'b1);
    commit_frame(1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b1, 1'b1);
    commit_frame(1'b0);
    settle();

    for (int p = 0; p < 6; p++) begin
      src_idle_pct <= (p % 4 == 1) ? 47 : (p % 4 == 3) ? 13 : 0;
      sink_stall_pct <= (p % 4 == 2) ? 47 : (p % 4 == 3) ? 13 : 0;
      if (p == 0) begin
        load_regs(0, 0, 0, 0, 0, 0, 2);
      end else if (p == 1) begin
        load_regs(100, 255, 255, 65535, 65535, 65535, 16);
      end else begin
        load_regs($urandom_range(100), $urandom_range(255), $urandom_range(255), pick_gain(),
                  pick_gain(), pick_gain(), (p == 2) ? 7 : $urandom_range(16, 2));
      end
      mark = queued_items;
      while (queued_items - mark < 55) build_frame($urandom_range(4, 1), 0);
      settle();
    end

    // Steady drift one way and then the other drives the integral far enough
    // to saturate the PID output at both ends.
    src_idle_pct <= 13;
    sink_stall_pct <= 13;
    thr = $urandom_range(254);
    load_regs(100, 0, thr, $urandom_range(65535), 65535, 65535, 2);
    for (int n = 0; n < 130; n++) begin
      add_pixel(pick_gray(0), 1'b0, 1'b0);
      add_pixel(pick_gray(100), 1'b1, 1'b1);
      commit_frame(1'b0);
    end
    for (int n = 0; n < 260; n++) begin
      add_pixel(pick_gray(100), 1'b1, 1'b1);
      commit_frame(1'b0);
    end
    settle();

    // The command side holds off while short frames keep closing, so the
    // summary queue fills and the pixel input has to stall.
    src_idle_pct <= 0;
    sink_stall_pct <= 0;
    load_regs($urandom_range(100), $urandom_range(64), $urandom_range(254), $urandom_range(4095),
              $urandom_range(255), $urandom_range(4095), 2);
    @(posedge clk_i);
    sink_hold_cycles <= 400;
    for (int n = 0; n < 60; n++) begin
      add_pixel(pick_gray(50), 1'b0, 1'b0);
      add_pixel(pick_gray(50), 1'b1, 1'b1);
      commit_frame(1'b0);
    end
    settle();

    // A frame width of 4096 with lines far shorter than a full line.
    src_idle_pct <= 47;
    sink_stall_pct <= 47;
    load_regs($urandom_range(100), $urandom_range(255), $urandom_range(255), pick_gain(),
              pick_gain(), pick_gain(), 4096);
    build_frame(1, 200);
    build_frame(2, 30);
    settle();

    // With no left half every frame meets the rush test; later pixels are ignored.
    src_idle_pct <= 0;
    sink_stall_pct <= 0;
    load_regs($urandom_range(100), 256, $urandom_range(255), pick_gain(), pick_gain(),
              pick_gain(), 1);
    add_pixel(pick_gray(50), 1'b0, 1'b0);
    add_pixel(pick_gray(50), 1'b0, 1'b0);
    add_pixel(pick_gray(50), 1'b1, 1'b1);
    commit_frame(1'b1);
    for (int n = 0; n < 5; n++) add_pixel(pick_gray(50), n == 4, n == 4);
    commit_frame(1'b1);
    settle();
    repeat (10) @(posedge clk_i);

    if (mismatch_cnt == 0 && steer_cmds_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/lfps_pkg.sv
src/lfps_intf.sv
src/lfps_front.sv
src/lfps_fifo.sv
src/lfps_back.sv
src/line_follow_pid_steering.sv
sim/tb.sv
